/* hdl/rpec_pkg.sv */
// Package for the rigid pose error check block: payload types, constants,
// slot and arctangent tables. No dependencies.
package rpec_pkg;

    localparam int ELEMENT_WIDTH  = 24;
    localparam int FRACTION_BITS  = 16;
    localparam int POSE_SLOTS     = 24;
    localparam int TEST_BASE      = 12;
    localparam int SLOT_WIDTH     = 5;
    localparam int TRANS_WIDTH    = 25;
    localparam int ANGLE_WIDTH    = 18;
    localparam int CFG_WIDTH      = 25;
    localparam int MUL_WIDTH      = 32;
    localparam int ZW             = 20;
    localparam int CORDIC_STEPS   = 16;
    localparam int PAIRS          = 12;
    localparam int TRANS_PAIRS    = 3;

    localparam logic [ANGLE_WIDTH-1:0] ANGLE_PI      = 18'd205887;
    localparam logic signed [ZW-1:0]   ANGLE_HALF_PI = 20'sd102944;
    localparam logic [TRANS_WIDTH-1:0] TRANS_RESET   = 25'd3277;
    localparam logic [ANGLE_WIDTH-1:0] ANGLE_RESET   = 18'd5719;

    // Configuration register indexes
    localparam logic REG_TRANS_LIMIT = 1'b0;
    localparam logic REG_ANGLE_LIMIT = 1'b1;

    typedef struct packed {
        logic [SLOT_WIDTH-1:0]           element_slot;
        logic signed [ELEMENT_WIDTH-1:0] element_value;
        logic                            compute_now;
    } rpec_in_t;

    typedef struct packed {
        logic [TRANS_WIDTH-1:0] translation_error;
        logic [ANGLE_WIDTH-1:0] angle_error;
        logic                   poses_match;
    } rpec_out_t;

    // Reference-pose slot of pair p: translation column first, then rotation
    function automatic logic [SLOT_WIDTH-1:0] pair_slot(input logic [3:0] p);
        logic [SLOT_WIDTH-1:0] s;
        case (p)
            4'd0:    s = 5'd3;
            4'd1:    s = 5'd7;
            4'd2:    s = 5'd11;
            4'd3:    s = 5'd0;
            4'd4:    s = 5'd1;
            4'd5:    s = 5'd2;
            4'd6:    s = 5'd4;
            4'd7:    s = 5'd5;
            4'd8:    s = 5'd6;
            4'd9:    s = 5'd8;
            4'd10:   s = 5'd9;
            4'd11:   s = 5'd10;
            default: s = 5'd0;
        endcase
        return s;
    endfunction

    // atan(2^-i) in Q16 radians
    function automatic logic signed [ZW-1:0] atan_at(input logic [3:0] i);
        logic signed [ZW-1:0] a;
        case (i)
            4'd0:    a = 20'sd51472;
            4'd1:    a = 20'sd30386;
            4'd2:    a = 20'sd16055;
            4'd3:    a = 20'sd8150;
            4'd4:    a = 20'sd4091;
            4'd5:    a = 20'sd2047;
            4'd6:    a = 20'sd1024;
            4'd7:    a = 20'sd512;
            4'd8:    a = 20'sd256;
            4'd9:    a = 20'sd128;
            4'd10:   a = 20'sd64;
            4'd11:   a = 20'sd32;
            4'd12:   a = 20'sd16;
            4'd13:   a = 20'sd8;
            4'd14:   a = 20'sd4;
            default: a = 20'sd2;
        endcase
        return a;
    endfunction

endpackage

/* hdl/rpec_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rpec_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 24
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

/* hdl/rpec_isqrt.sv */
// Iterative 64-bit integer square root, one result bit per cycle.
// No dependencies.
module rpec_isqrt (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] radicand,
    output logic        done,
    output logic [31:0] root
);
    logic [63:0] n_reg, n_next;
    logic [63:0] res_reg, res_next;
    logic [63:0] bit_reg, bit_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [63:0] trial;

    // One restoring step per cycle
    always_comb begin
        trial     = res_reg + bit_reg;
        n_next    = n_reg;
        res_next  = res_reg;
        bit_next  = bit_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            n_next    = radicand;
            res_next  = '0;
            bit_next  = 64'd1 << 62;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (n_reg >= trial) begin
                n_next   = n_reg - trial;
                res_next = (res_reg >> 1) + bit_reg;
            end else begin
                res_next = res_reg >> 1;
            end
            bit_next = bit_reg >> 2;
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd31) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        n_reg   <= n_next;
        res_reg <= res_next;
        bit_reg <= bit_next;
    end

    assign done = done_reg;
    assign root = res_reg[31:0];
endmodule

/* hdl/rigid_pose_error_check.sv */
// Rigid pose error check, top level.
// Depends on rpec_pkg, rpec_ram and rpec_isqrt.
//
// Usage: pose elements arrive on the s_ channel one request at a time, each
// with its slot (0-11 reference, 12-23 test, row*4+column). Slots 24-31 are
// dropped. A request with compute_now set is stored and then starts the
// computation; one result request leaves on the m_ channel with the
// translation error, rotation angle and match flag.
// Loading requests are taken whenever the sequencer is idle. A compute
// request keeps s_ready low until its result enters the output register:
// 24 pose-memory reads through the shared multiplier plus drain, two square
// roots on the shared root unit and 16 CORDIC iterations, mostly the roots.
// The result sits in an output register; if the receiver stalls, new
// elements are still taken, and only the next compute waits for the
// register to empty before finishing.
// Reset (aresetn low, synchronous) returns the sequencer to idle, drops any
// pending result and restores the limits to 0.05 m and five degrees. The
// pose memory is not cleared; compute only after loading all 24 elements.
// The user writes limits via cfg_we/cfg_index/cfg_wdata, idle only; not enforced.
module rigid_pose_error_check #(
    parameter int FRACTION_BITS = rpec_pkg::FRACTION_BITS
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  rpec_pkg::rpec_in_t                  s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output rpec_pkg::rpec_out_t                 m_data,
    input  logic                                cfg_we,
    input  logic                                cfg_index,
    input  logic [rpec_pkg::CFG_WIDTH-1:0]      cfg_wdata
);
    import rpec_pkg::*;

    localparam int AW  = $clog2(POSE_SLOTS);
    localparam int LSH = (2 * FRACTION_BITS < 30) ? 30 - 2 * FRACTION_BITS : 0;
    localparam int RSH = (2 * FRACTION_BITS >= 30) ? 2 * FRACTION_BITS - 30 : 0;
    localparam logic signed [63:0] ONE   = 64'sd1 <<< (2 * FRACTION_BITS);
    localparam logic signed [63:0] RMASK = (64'sd1 <<< RSH) - 64'sd1;
    localparam logic [TRANS_WIDTH-1:0] TRANS_MAX = '1;

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_FETCH  = 4'd1;
    localparam logic [3:0] ST_DRAIN  = 4'd2;
    localparam logic [3:0] ST_TSQ    = 4'd3;
    localparam logic [3:0] ST_CLAMP  = 4'd4;
    localparam logic [3:0] ST_CQ     = 4'd5;
    localparam logic [3:0] ST_SQW    = 4'd6;
    localparam logic [3:0] ST_SQS    = 4'd7;
    localparam logic [3:0] ST_VSQ    = 4'd8;
    localparam logic [3:0] ST_CORDIC = 4'd9;
    localparam logic [3:0] ST_OUT    = 4'd10;

    logic [3:0] state_reg, state_next;
    logic [4:0] cnt_reg, cnt_next;
    logic [3:0] cidx_reg, cidx_next;

    logic [TRANS_WIDTH-1:0] tlim_reg;
    logic [ANGLE_WIDTH-1:0] alim_reg;

    // fetch pipeline flags
    logic rd_vld_reg, rd_odd_reg, rd_tr_reg;
    logic op_vld_reg, op_tr_reg;
    logic pr_vld_reg, pr_tr_reg;

    logic [ELEMENT_WIDTH-1:0]        rd_data;
    logic [AW-1:0]                   raddr;
    logic signed [ELEMENT_WIDTH-1:0] a_reg;
    logic signed [MUL_WIDTH-1:0]     mul_a_reg, mul_a_next;
    logic signed [MUL_WIDTH-1:0]     mul_b_reg, mul_b_next;
    logic signed [63:0]              prod_reg;
    logic [63:0]                     tsum_reg;
    logic [63:0]                     ssum_reg;
    logic signed [63:0]              c_reg;
    logic signed [31:0]              cq_reg;
    logic [31:0]                     tr_reg;

    logic signed [33:0] x_reg, x_next;
    logic signed [33:0] y_reg, y_next;
    logic signed [ZW-1:0] z_reg, z_next;

    logic        m_valid_reg;
    rpec_out_t   m_data_reg;

    logic        s_fire;
    logic        sqrt_start;
    logic        sqrt_done;
    logic [63:0] sqrt_rad;
    logic [31:0] sqrt_root;
    logic        drained;
    logic [3:0]  pair;

    logic signed [63:0]          v_wide, c_wide, cq_wide;
    logic signed [MUL_WIDTH-1:0] rd_ext, a_ext;
    logic signed [33:0]          xs, ys;
    logic [ANGLE_WIDTH-1:0]      angle;
    logic [TRANS_WIDTH-1:0]      trans;

    assign s_ready = (state_reg == ST_IDLE);
    assign s_fire  = s_valid && s_ready;
    assign drained = !rd_vld_reg && !op_vld_reg && !pr_vld_reg;
    assign pair    = cnt_reg[4:1];

    // Pose memory: written on each accepted request with a slot below 24, read by the sequencer
    assign raddr = AW'(pair_slot(pair)) + (cnt_reg[0] ? AW'(TEST_BASE) : AW'(0));

    rpec_ram #(
        .WIDTH (ELEMENT_WIDTH),
        .DEPTH (POSE_SLOTS)
    ) u_ram (
        .aclk  (aclk),
        .we    (s_fire && (s_data.element_slot < SLOT_WIDTH'(POSE_SLOTS))),
        .waddr (s_data.element_slot[AW-1:0]),
        .wdata (s_data.element_value),
        .raddr (raddr),
        .rdata (rd_data)
    );

    // Shared square root unit
    assign sqrt_start = (state_reg == ST_DRAIN && drained) || (state_reg == ST_SQS);
    assign sqrt_rad   = (state_reg == ST_SQS) ? (64'd1 << 60) - 64'(prod_reg) : tsum_reg;

    rpec_isqrt u_isqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sqrt_start),
        .radicand (sqrt_rad),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

    // Cosine term arithmetic
    always_comb begin
        v_wide  = $signed(ssum_reg) - ONE;
        c_wide  = (v_wide + $signed({63'd0, v_wide[63]})) >>> 1;
        cq_wide = ((c_reg <<< LSH) + (c_reg[63] ? RMASK : 64'sd0)) >>> RSH;
    end

    assign rd_ext = MUL_WIDTH'($signed(rd_data));
    assign a_ext  = MUL_WIDTH'(a_reg);
    assign xs     = x_reg >>> cidx_reg;
    assign ys     = y_reg >>> cidx_reg;

    // Final saturation
    assign angle = (z_reg < 0) ? '0 :
                   (z_reg > $signed({2'b00, ANGLE_PI})) ? ANGLE_PI : z_reg[ANGLE_WIDTH-1:0];
    assign trans = (tr_reg > 32'(TRANS_MAX)) ? TRANS_MAX : tr_reg[TRANS_WIDTH-1:0];

    // Sequencer
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cidx_next  = cidx_reg;
        mul_a_next = mul_a_reg;
        mul_b_next = mul_b_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        z_next     = z_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_fire && s_data.compute_now) begin
                    state_next = ST_FETCH;
                    cnt_next   = '0;
                end
            end
            ST_FETCH: begin
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'(2 * PAIRS - 1)) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (drained) begin
                    state_next = ST_TSQ;
                end
            end
            ST_TSQ: begin
                if (sqrt_done) begin
                    state_next = ST_CLAMP;
                end
            end
            ST_CLAMP: state_next = ST_CQ;
            ST_CQ: begin
                mul_a_next = cq_wide[MUL_WIDTH-1:0];
                mul_b_next = cq_wide[MUL_WIDTH-1:0];
                state_next = ST_SQW;
            end
            ST_SQW: state_next = ST_SQS;
            ST_SQS: state_next = ST_VSQ;
            ST_VSQ: begin
                if (sqrt_done) begin
                    cidx_next  = '0;
                    state_next = ST_CORDIC;
                    if (cq_reg < 0) begin
                        x_next = {2'b00, sqrt_root};
                        y_next = -34'(cq_reg);
                        z_next = ANGLE_HALF_PI;
                    end else begin
                        x_next = 34'(cq_reg);
                        y_next = {2'b00, sqrt_root};
                        z_next = '0;
                    end
                end
            end
            ST_CORDIC: begin
                if (y_reg > 0) begin
                    x_next = x_reg + ys;
                    y_next = y_reg - xs;
                    z_next = z_reg + atan_at(cidx_reg);
                end else begin
                    x_next = x_reg - ys;
                    y_next = y_reg + xs;
                    z_next = z_reg - atan_at(cidx_reg);
                end
                cidx_next = cidx_reg + 4'd1;
                if (cidx_reg == 4'(CORDIC_STEPS - 1)) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase

        // Fetch pipeline operand load: difference for translation pairs
        if (rd_vld_reg && rd_odd_reg) begin
            if (rd_tr_reg) begin
                mul_a_next = a_ext - rd_ext;
                mul_b_next = a_ext - rd_ext;
            end else begin
                mul_a_next = a_ext;
                mul_b_next = rd_ext;
            end
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            cidx_reg    <= '0;
            rd_vld_reg  <= 1'b0;
            op_vld_reg  <= 1'b0;
            pr_vld_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
            tlim_reg    <= TRANS_RESET;
            alim_reg    <= ANGLE_RESET;
        end else begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            cidx_reg   <= cidx_next;
            rd_vld_reg <= (state_reg == ST_FETCH);
            op_vld_reg <= rd_vld_reg && rd_odd_reg;
            pr_vld_reg <= op_vld_reg;
            if (cfg_we) begin
                case (cfg_index)
                    REG_TRANS_LIMIT: tlim_reg <= cfg_wdata[TRANS_WIDTH-1:0];
                    REG_ANGLE_LIMIT: alim_reg <= cfg_wdata[ANGLE_WIDTH-1:0];
                    default: ;
                endcase
            end
            if (state_reg == ST_OUT && (!m_valid_reg || m_ready)) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        rd_odd_reg <= cnt_reg[0];
        rd_tr_reg  <= (pair < 4'(TRANS_PAIRS));
        op_tr_reg  <= rd_tr_reg;
        pr_tr_reg  <= op_tr_reg;
        mul_a_reg  <= mul_a_next;
        mul_b_reg  <= mul_b_next;
        prod_reg   <= mul_a_reg * mul_b_reg;
        x_reg      <= x_next;
        y_reg      <= y_next;
        z_reg      <= z_next;
        if (rd_vld_reg && !rd_odd_reg) begin
            a_reg <= $signed(rd_data);
        end
        // accumulate products
        if (state_reg == ST_IDLE) begin
            tsum_reg <= '0;
            ssum_reg <= '0;
        end else if (pr_vld_reg) begin
            if (pr_tr_reg) begin
                tsum_reg <= tsum_reg + 64'(prod_reg);
            end else begin
                ssum_reg <= ssum_reg + 64'(prod_reg);
            end
        end
        if (state_reg == ST_TSQ && sqrt_done) begin
            tr_reg <= sqrt_root;
        end
        if (state_reg == ST_CLAMP) begin
            c_reg <= (c_wide > ONE) ? ONE : (c_wide < -ONE) ? -ONE : c_wide;
        end
        if (state_reg == ST_CQ) begin
            cq_reg <= cq_wide[31:0];
        end
        if (state_reg == ST_OUT && (!m_valid_reg || m_ready)) begin
            m_data_reg.translation_error <= trans;
            m_data_reg.angle_error       <= angle;
            m_data_reg.poses_match       <= (trans <= tlim_reg) && (angle <= alim_reg);
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Root unit finishes only while the sequencer waits for it
    a_sqrt_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        sqrt_done |-> (state_reg == ST_TSQ || state_reg == ST_VSQ))
        else $error("root unit finished outside a wait state");

    // Angle output stays within 0..pi
    a_angle_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.angle_error <= ANGLE_PI))
        else $error("angle result out of range");

    // A new result only follows the output state
    a_out_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> ($past(state_reg) == ST_OUT))
        else $error("result raised outside output state");

    // No element is accepted during the fetch or CORDIC states
    a_no_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CORDIC || state_reg == ST_FETCH) |-> !s_ready)
        else $error("input ready during computation");
endmodule
